// ===== rtl/assert_macros.svh =====
// assertion macros used by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/ffa_pkg.sv =====
// shared types and constants of the first-fit allocator
`timescale 1ns / 1ps
package ffa_pkg;
    localparam int REQ_W    = 13;
    localparam int ADDR_W   = 12;
    localparam int STATUS_W = 2;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_ZERO    = 2'd1,
        ST_NOFIT   = 2'd2,
        ST_BADFREE = 2'd3
    } t_status;
endpackage

// ===== rtl/ffa_if.sv =====
// request and response channel interfaces
`timescale 1ns / 1ps
interface ffa_req_if;
    logic                      valid;
    logic                      ready;
    logic                      mode;
    logic [ffa_pkg::REQ_W-1:0]  request_bytes;
    logic [ffa_pkg::ADDR_W-1:0] free_address;

    modport source (output valid, mode, request_bytes, free_address, input ready);
    modport sink   (input valid, mode, request_bytes, free_address, output ready);
endinterface

interface ffa_rsp_if;
    logic                       valid;
    logic                       ready;
    ffa_pkg::t_status           status;
    logic [ffa_pkg::ADDR_W-1:0] payload_address;

    modport source (output valid, status, payload_address, input ready);
    modport sink   (input valid, status, payload_address, output ready);
endinterface

// ===== rtl/ffa_mem.sv =====
// segment table memory, one write port and one registered read port
`timescale 1ns / 1ps
module ffa_mem #(
    parameter int DEPTH = 128,
    parameter int WIDTH = 27
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/first_fit_heap_allocator.sv =====
// first-fit heap allocator: sequencer around one table memory
// allocate: round (S_RND1..S_RND3), walk (S_SCAN), shift (S_SHFT), S_FIN; free: walk,
// neighbour reads (S_FNXT, S_FPRV), merge (S_FMRG), shift, S_FIN; the shift moves one entry a
// cycle; no fit and bad free leave the walk for S_FIN, zero size and null free go straight to
// S_FIN; one request at a time, ready again as the response goes valid; a held response
// stalls it; reset (synchronous, active low), then S_INIT writes the initial free segment
`timescale 1ns / 1ps
`include "assert_macros.svh"
module first_fit_heap_allocator #(
    parameter int HEAP_BYTES   = 4096,
    parameter int HEADER_BYTES = 32,
    parameter int ALIGN_BYTES  = 8,
    parameter int MAX_SEGMENTS = 128
) (
    input  logic i_clk,
    input  logic i_rst_n,
    ffa_req_if.sink   i_req,
    ffa_rsp_if.source o_rsp
);
    localparam int HW  = $clog2(HEAP_BYTES + 1);
    localparam int DW  = (HW + 1 > 15) ? HW + 1 : 15;
    localparam int IW  = $clog2(MAX_SEGMENTS);
    localparam int CW  = $clog2(MAX_SEGMENTS + 1);
    localparam int EW  = 2 * HW + 1;
    localparam int SH  = 21;
    localparam int RW  = SH + 1;
    localparam int PW  = DW + RW;
    localparam logic [RW-1:0] RECIP = RW'((1 << SH) / ALIGN_BYTES);
    localparam logic [DW-1:0] HDR   = DW'(HEADER_BYTES);
    localparam logic [DW-1:0] ALN   = DW'(ALIGN_BYTES);

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_RND1, S_RND2, S_RND3, S_SCAN,
        S_FNXT, S_FPRV, S_FMRG, S_SHFT, S_FIN
    } t_state;

    t_state r_state, n_state;
    logic                      r_mode, n_mode;
    logic [ffa_pkg::ADDR_W-1:0] r_faddr, n_faddr;
    logic [DW-1:0]             r_x, n_x;
    logic [PW-1:0]             r_prod, n_prod;
    logic [DW-1:0]             r_need, n_need;
    logic [CW-1:0]             r_count, n_count;
    logic [IW-1:0]             r_idx, n_idx;
    logic [IW-1:0]             r_rd_idx, n_rd_idx;
    logic                      r_rd_v, n_rd_v;
    logic [IW-1:0]             r_h, n_h;
    logic [HW-1:0]             r_off, n_off;
    logic [DW-1:0]             r_size, n_size;
    logic                      r_ins, n_ins;
    logic [HW-1:0]             r_new_off, n_new_off;
    logic [HW-1:0]             r_new_size, n_new_size;
    logic                      r_up, n_up;
    logic [1:0]                r_d, n_d;
    logic [IW-1:0]             r_k, n_k;
    logic [CW-1:0]             r_n, n_n;
    logic                      r_mn, n_mn;
    ffa_pkg::t_status          r_status, n_status;
    logic [ffa_pkg::ADDR_W-1:0] r_addr, n_addr;
    logic                      r_out_v, n_out_v;
    ffa_pkg::t_status          r_out_status, n_out_status;
    logic [ffa_pkg::ADDR_W-1:0] r_out_addr, n_out_addr;

    logic          m_we;
    logic [IW-1:0] m_waddr, m_raddr;
    logic [EW-1:0] m_wdata, m_rdata;

    logic [HW-1:0] e_off, e_size;
    logic          e_free;
    logic [DW-1:0] e_off_x, e_size_x, rest;
    logic          split, hit, last, fin_go, nx_ok, pv;
    logic [CW:0]   sh_s, sh_first, sh_n;
    logic [1:0]    sh_d;
    logic [DW-1:0] merged;

    assign e_free   = m_rdata[0];
    assign e_size   = m_rdata[HW:1];
    assign e_off    = m_rdata[2*HW:HW+1];
    assign e_off_x  = DW'(e_off);
    assign e_size_x = DW'(e_size);
    assign rest     = e_size_x - r_need;
    assign split    = (rest >= HDR) && (r_count < CW'(MAX_SEGMENTS));
    // the one compare of the walk: fit test on allocate, address match on free
    assign hit      = r_mode ? ((e_off_x + HDR) == DW'(r_faddr))
                             : (e_free && (e_size_x >= r_need));
    assign last     = (CW'(r_rd_idx) == (r_count - CW'(1)));
    assign fin_go   = !r_out_v || o_rsp.ready;
    assign nx_ok    = ((CW'(r_h) + CW'(1)) < r_count);
    assign pv       = (r_h != '0) && e_free;
    assign merged   = e_size_x + r_size + HDR;

    always_comb begin
        n_state      = r_state;
        n_mode       = r_mode;
        n_faddr      = r_faddr;
        n_x          = r_x;
        n_prod       = r_prod;
        n_need       = r_need;
        n_count      = r_count;
        n_idx        = r_idx;
        n_rd_idx     = r_rd_idx;
        n_rd_v       = r_rd_v;
        n_h          = r_h;
        n_off        = r_off;
        n_size       = r_size;
        n_ins        = r_ins;
        n_new_off    = r_new_off;
        n_new_size   = r_new_size;
        n_up         = r_up;
        n_d          = r_d;
        n_k          = r_k;
        n_n          = r_n;
        n_mn         = r_mn;
        n_status     = r_status;
        n_addr       = r_addr;
        n_out_v      = r_out_v;
        n_out_status = r_out_status;
        n_out_addr   = r_out_addr;
        m_we         = 1'b0;
        m_waddr      = r_h;
        m_wdata      = '0;
        m_raddr      = r_idx;
        sh_s         = '0;
        sh_d         = '0;
        sh_first     = '0;
        sh_n         = '0;

        if (r_out_v && o_rsp.ready) begin
            n_out_v = 1'b0;
        end

        case (r_state)
            S_INIT: begin
                m_we    = 1'b1;
                m_waddr = '0;
                m_wdata = {HW'(0), HW'(HEAP_BYTES - HEADER_BYTES), 1'b1};
                n_count = CW'(1);
                n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_req.valid) begin
                    n_mode   = i_req.mode;
                    n_faddr  = i_req.free_address;
                    n_ins    = 1'b0;
                    n_d      = '0;
                    n_status = ffa_pkg::ST_OK;
                    n_addr   = '0;
                    n_idx    = '0;
                    n_rd_v   = 1'b0;
                    if (!i_req.mode) begin
                        if (i_req.request_bytes == '0) begin
                            n_status = ffa_pkg::ST_ZERO;
                            n_state  = S_FIN;
                        end else begin
                            n_x     = DW'(i_req.request_bytes) + DW'(ALIGN_BYTES - 1);
                            n_state = S_RND1;
                        end
                    end else if (i_req.free_address == '0) begin
                        n_state = S_FIN;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            // round up: quotient estimate by reciprocal, then one correction
            S_RND1: begin
                n_prod  = PW'(r_x) * PW'(RECIP);
                n_state = S_RND2;
            end
            S_RND2: begin
                n_need  = DW'(DW'(r_prod >> SH) * ALN);
                n_state = S_RND3;
            end
            S_RND3: begin
                if ((r_x - r_need) >= ALN) begin
                    n_need = r_need + ALN;
                end
                n_state = S_SCAN;
            end
            S_SCAN: begin
                m_raddr = r_idx;
                if (r_rd_v && hit) begin
                    n_h    = r_rd_idx;
                    n_rd_v = 1'b0;
                    if (!r_mode) begin
                        m_we       = 1'b1;
                        m_waddr    = r_rd_idx;
                        m_wdata    = {e_off, (split ? HW'(r_need) : e_size), 1'b0};
                        n_ins      = split;
                        n_new_off  = HW'(e_off_x + HDR + r_need);
                        n_new_size = HW'(rest - HDR);
                        n_addr     = ffa_pkg::ADDR_W'(e_off_x + HDR);
                        n_up       = 1'b1;
                        n_k        = IW'(r_count - CW'(1));
                        n_n        = split ? (r_count - CW'(1) - CW'(r_rd_idx)) : '0;
                        n_state    = S_SHFT;
                    end else if (e_free) begin
                        n_status = ffa_pkg::ST_BADFREE;
                        n_state  = S_FIN;
                    end else begin
                        n_off   = e_off;
                        n_size  = e_size_x;
                        n_state = S_FNXT;
                    end
                end else if (r_rd_v && last) begin
                    n_status = r_mode ? ffa_pkg::ST_BADFREE : ffa_pkg::ST_NOFIT;
                    n_state  = S_FIN;
                end else begin
                    n_idx    = r_idx + IW'(1);
                    n_rd_idx = r_idx;
                    n_rd_v   = 1'b1;
                end
            end
            S_FNXT: begin
                m_raddr = r_h + IW'(1);
                n_state = S_FPRV;
            end
            S_FPRV: begin
                m_raddr = r_h - IW'(1);
                n_mn    = nx_ok && e_free;
                if (nx_ok && e_free) begin
                    n_size = r_size + e_size_x + HDR;
                end
                n_state = S_FMRG;
            end
            S_FMRG: begin
                m_we = 1'b1;
                if (pv) begin
                    m_waddr = r_h - IW'(1);
                    m_wdata = {e_off, HW'(merged), 1'b1};
                    sh_s    = (CW + 1)'(r_h);
                    sh_d    = r_mn ? 2'd2 : 2'd1;
                end else begin
                    m_waddr = r_h;
                    m_wdata = {r_off, HW'(r_size), 1'b1};
                    sh_s    = (CW + 1)'(r_h) + (CW + 1)'(1);
                    sh_d    = r_mn ? 2'd1 : 2'd0;
                end
                sh_first = sh_s + (CW + 1)'(sh_d);
                sh_n     = (CW + 1)'(r_count) - sh_first;
                n_d      = sh_d;
                n_up     = 1'b0;
                n_k      = IW'(sh_first);
                n_n      = (sh_d == 2'd0) ? '0 : CW'(sh_n);
                n_rd_v   = 1'b0;
                n_state  = S_SHFT;
            end
            // move entries one a cycle: read at r_k, write the last read to its new place
            S_SHFT: begin
                m_raddr = r_k;
                if (r_rd_v) begin
                    m_we    = 1'b1;
                    m_waddr = r_up ? (r_rd_idx + IW'(1)) : (r_rd_idx - IW'(r_d));
                    m_wdata = m_rdata;
                end
                if (r_n != '0) begin
                    n_rd_idx = r_k;
                    n_rd_v   = 1'b1;
                    n_k      = r_up ? (r_k - IW'(1)) : (r_k + IW'(1));
                    n_n      = r_n - CW'(1);
                end else begin
                    n_rd_v = 1'b0;
                    if (!r_rd_v) begin
                        n_state = S_FIN;
                    end
                end
            end
            S_FIN: begin
                if (fin_go) begin
                    if (r_ins) begin
                        m_we    = 1'b1;
                        m_waddr = r_h + IW'(1);
                        m_wdata = {r_new_off, r_new_size, 1'b1};
                    end
                    n_count      = r_count + CW'(r_ins) - CW'(r_d);
                    n_out_v      = 1'b1;
                    n_out_status = r_status;
                    n_out_addr   = r_addr;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_count <= CW'(1);
            r_rd_v  <= 1'b0;
            r_out_v <= 1'b0;
            r_ins   <= 1'b0;
            r_d     <= '0;
            r_n     <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_rd_v  <= n_rd_v;
            r_out_v <= n_out_v;
            r_ins   <= n_ins;
            r_d     <= n_d;
            r_n     <= n_n;
        end
        r_mode       <= n_mode;
        r_faddr      <= n_faddr;
        r_x          <= n_x;
        r_prod       <= n_prod;
        r_need       <= n_need;
        r_idx        <= n_idx;
        r_rd_idx     <= n_rd_idx;
        r_h          <= n_h;
        r_off        <= n_off;
        r_size       <= n_size;
        r_new_off    <= n_new_off;
        r_new_size   <= n_new_size;
        r_up         <= n_up;
        r_k          <= n_k;
        r_mn         <= n_mn;
        r_status     <= n_status;
        r_addr       <= n_addr;
        r_out_status <= n_out_status;
        r_out_addr   <= n_out_addr;
    end

    ffa_mem #(
        .DEPTH (MAX_SEGMENTS),
        .WIDTH (EW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (m_we),
        .i_waddr (m_waddr),
        .i_wdata (m_wdata),
        .i_raddr (m_raddr),
        .o_rdata (m_rdata)
    );

    assign i_req.ready           = (r_state == S_IDLE);
    assign o_rsp.valid           = r_out_v;
    assign o_rsp.status          = r_out_status;
    assign o_rsp.payload_address = r_out_addr;

    `ASSERT_ALWAYS(a_count_range, i_clk, i_rst_n,
        (r_count != '0) && (r_count <= CW'(MAX_SEGMENTS)))
    `ASSERT_NEXT(a_fin_resp, i_clk, i_rst_n, (r_state == S_FIN) && fin_go, o_rsp.valid)
    `ASSERT_ALWAYS(a_err_no_addr, i_clk, i_rst_n,
        !o_rsp.valid || (o_rsp.status == ffa_pkg::ST_OK) || (o_rsp.payload_address == '0))
    `ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_req.valid && i_req.ready, !i_req.ready)
endmodule

// ===== sim/tb_first_fit_heap_allocator.sv =====
// testbench for the first-fit heap allocator: random and directed requests, scoreboard checked
`timescale 1ns / 1ps
module tb_first_fit_heap_allocator;
    localparam int HEAP   = 4096;
    localparam int HDR    = 32;
    localparam int ALIGN  = 8;
    localparam int MAXSEG = 128;

    typedef struct packed {
        ffa_pkg::t_status           status;
        logic [ffa_pkg::ADDR_W-1:0] addr;
    } t_grant;

    // heap segment table mirror, predicts each response
    class heap_scoreboard;
        int unsigned seg_off[MAXSEG];
        int unsigned seg_size[MAXSEG];
        bit          seg_free[MAXSEG];
        int unsigned seg_count;
        t_grant      pending[$];
        int unsigned mismatches;
        int unsigned checked;
        int unsigned n_ok, n_zero, n_nofit, n_bad;

        function void clear_heap();
            seg_off[0]  = 0;
            seg_size[0] = HEAP - HDR;
            seg_free[0] = 1'b1;
            seg_count   = 1;
        endfunction

        function void remove_seg(int unsigned idx);
            for (int unsigned k = idx; k + 1 < seg_count; k++) begin
                seg_off[k]  = seg_off[k+1];
                seg_size[k] = seg_size[k+1];
                seg_free[k] = seg_free[k+1];
            end
            seg_count--;
        endfunction

        function t_grant predict_alloc(int unsigned req);
            t_grant g;
            int unsigned need, rest;
            g.status = ffa_pkg::ST_NOFIT;
            g.addr   = '0;
            if (req == 0) begin
                g.status = ffa_pkg::ST_ZERO;
                return g;
            end
            need = ((req + ALIGN - 1) / ALIGN) * ALIGN;
            for (int unsigned i = 0; i < seg_count; i++) begin
                if (seg_free[i] && seg_size[i] >= need) begin
                    rest = seg_size[i] - need;
                    if (rest >= HDR && seg_count < MAXSEG) begin
                        for (int unsigned k = seg_count; k > i + 1; k--) begin
                            seg_off[k]  = seg_off[k-1];
                            seg_size[k] = seg_size[k-1];
                            seg_free[k] = seg_free[k-1];
                        end
                        seg_off[i+1]  = seg_off[i] + HDR + need;
                        seg_size[i+1] = rest - HDR;
                        seg_free[i+1] = 1'b1;
                        seg_count++;
                        seg_size[i] = need;
                    end
                    seg_free[i] = 1'b0;
                    g.status = ffa_pkg::ST_OK;
                    g.addr   = ffa_pkg::ADDR_W'(seg_off[i] + HDR);
                    return g;
                end
            end
            return g;
        endfunction

        function ffa_pkg::t_status predict_free(int unsigned fa);
            int unsigned i;
            if (fa == 0) return ffa_pkg::ST_OK;
            for (i = 0; i < seg_count; i++)
                if (seg_off[i] + HDR == fa) break;
            if (i >= seg_count || seg_free[i]) return ffa_pkg::ST_BADFREE;
            seg_free[i] = 1'b1;
            if (i + 1 < seg_count && seg_free[i+1]) begin
                seg_size[i] += seg_size[i+1] + HDR;
                remove_seg(i + 1);
            end
            if (i > 0 && seg_free[i-1]) begin
                seg_size[i-1] += seg_size[i] + HDR;
                remove_seg(i);
            end
            return ffa_pkg::ST_OK;
        endfunction

        function void note_request(logic m, logic [ffa_pkg::REQ_W-1:0] rb,
                                   logic [ffa_pkg::ADDR_W-1:0] fa);
            t_grant g;
            if (m == 1'b0) begin
                g = predict_alloc(rb);
            end else begin
                g.status = predict_free(fa);
                g.addr   = '0;
            end
            case (g.status)
                ffa_pkg::ST_OK:    n_ok++;
                ffa_pkg::ST_ZERO:  n_zero++;
                ffa_pkg::ST_NOFIT: n_nofit++;
                default:           n_bad++;
            endcase
            pending.push_back(g);
        endfunction

        function void check_response(ffa_pkg::t_status st, logic [ffa_pkg::ADDR_W-1:0] ad);
            t_grant g;
            checked++;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected response status=%0d addr=%0d", st, ad);
                return;
            end
            g = pending.pop_front();
            if (st !== g.status || ad !== g.addr) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected status=%0d addr=%0d, got status=%0d addr=%0d",
                             g.status, g.addr, st, ad);
            end
        endfunction

        // live allocated payload addresses, for well-formed frees
        function int unsigned pick_live();
            int unsigned cand[$];
            for (int unsigned i = 0; i < seg_count; i++)
                if (!seg_free[i]) cand.push_back(seg_off[i] + HDR);
            if (cand.size() == 0) return 0;
            return cand[$urandom_range(cand.size() - 1)];
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    ffa_req_if req_ch();
    ffa_rsp_if rsp_ch();

    first_fit_heap_allocator u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch.sink),
        .o_rsp  (rsp_ch.source)
    );

    heap_scoreboard sb;
    bit calm;          // no idling on either side
    bit stim_done;

    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        req_ch.valid         = 1'b0;
        req_ch.mode          = 1'b0;
        req_ch.request_bytes = '0;
        req_ch.free_address  = '0;
        rsp_ch.ready         = 1'b0;
        i_rst_n              = 1'b0;
        sb = new();
        sb.clear_heap();
    end

    // response side: random stalls, checks every transfer
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (rsp_ch.valid && rsp_ch.ready)
                sb.check_response(rsp_ch.status, rsp_ch.payload_address);
            rsp_ch.ready <= calm ? 1'b1 : ($urandom_range(99) >= 20);
        end
    end

    // valid stays high into the next request unless an idle cycle comes between
    task automatic send_request(logic m, logic [ffa_pkg::REQ_W-1:0] rb,
                                logic [ffa_pkg::ADDR_W-1:0] fa);
        while (!calm && $urandom_range(99) < 20) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.mode          <= m;
        req_ch.request_bytes <= rb;
        req_ch.free_address  <= fa;
        do @(posedge i_clk); while (!req_ch.ready);
        sb.note_request(m, rb, fa);
    endtask

    task automatic send_random();
        int unsigned r;
        int unsigned a;
        r = $urandom_range(99);
        if (r < 45) begin
            // mostly small sizes so the table fills up
            if ($urandom_range(9) == 0)
                send_request(1'b0, ffa_pkg::REQ_W'($urandom_range(8191)),
                             ffa_pkg::ADDR_W'($urandom));
            else
                send_request(1'b0, ffa_pkg::REQ_W'($urandom_range(120)),
                             ffa_pkg::ADDR_W'($urandom));
        end else if (r < 85) begin
            a = sb.pick_live();
            send_request(1'b1, ffa_pkg::REQ_W'($urandom), ffa_pkg::ADDR_W'(a));
        end else if (r < 93) begin
            send_request(1'b1, ffa_pkg::REQ_W'($urandom), ffa_pkg::ADDR_W'($urandom));
        end else begin
            // free of the first payload address, or a null free
            send_request(1'b1, ffa_pkg::REQ_W'($urandom),
                         ($urandom_range(1) == 0) ? '0 : ffa_pkg::ADDR_W'(HDR));
        end
    endtask

    initial begin
        int unsigned a;
        calm      = 1'b0;
        stim_done = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part
        send_request(1'b0, '0, '0);                       // zero size
        send_request(1'b0, 13'd4096, '0);                 // no fit
        send_request(1'b0, 13'd8191, 12'hFFF);            // all bits of size
        send_request(1'b0, 13'd4064, '0);                 // exact whole heap
        send_request(1'b1, '0, 12'd32);                   // free it
        send_request(1'b1, 13'h1FFF, 12'd32);             // double free
        send_request(1'b1, '0, '0);                       // null free
        send_request(1'b1, '0, 12'hFFF);                  // bad address
        send_request(1'b0, 13'd1, '0);
        send_request(1'b0, 13'd9, '0);
        send_request(1'b0, 13'd4000, '0);                 // no fit, larger than the free remainder
        send_request(1'b0, 13'd3900, '0);
        send_request(1'b1, '0, 12'd72);                   // middle
        send_request(1'b1, '0, 12'd32);                   // merge with next
        send_request(1'b1, '0, 12'd120);                  // merge both sides
        send_request(1'b1, '0, 12'd33);                   // not a payload address
        // fill the heap until allocations no longer fit
        for (int i = 0; i < 140; i++) send_request(1'b0, 13'd1, '0);
        for (int i = 0; i < 60; i++) begin
            a = sb.pick_live();
            send_request(1'b1, '0, ffa_pkg::ADDR_W'(a));
        end

        // random part, with one calm stretch
        for (int i = 0; i < 1350; i++) begin
            calm = (i >= 600 && i < 850);
            send_random();
        end
        req_ch.valid <= 1'b0;
        calm = 1'b0;
        stim_done = 1'b1;
    end

    initial begin
        wait (stim_done);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        $display("covered %0d responses: %0d ok, %0d zero size, %0d no fit, %0d bad free",
                 sb.checked, sb.n_ok, sb.n_zero, sb.n_nofit, sb.n_bad);
        $display("mismatches: %0d", sb.mismatches);
        if (sb.mismatches == 0)
            $display("first_fit_heap_allocator verification clean");
        else
            $display("first_fit_heap_allocator verification failed");
        $finish;
    end

    initial begin
        #4000000;
        $display("timeout");
        $display("first_fit_heap_allocator verification failed");
        $finish;
    end
endmodule
